### rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and the arctangent table for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int WORD_W = 34;
   typedef logic signed [WORD_W-1:0] cordic_word_type;

   // Square root input is a 33-bit value shifted up by 28, padded to 62 bits.
   localparam int SQRT_STEPS = 31;
   localparam int SQRT_IN_W = 33;

   localparam logic [31:0] RAD_MUL = 32'd4024455254;
   localparam cordic_word_type CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
   localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
   localparam logic signed [33:0] ONE_TURN = 34'sd3600000000;
   localparam logic [34:0] DIST_MAX = 35'd20106192983;
   localparam logic [9:0] MM_PER_M = 10'd1000;
   localparam logic [32:0] RADIUS_MM_RESET = 33'd6371000000;

   // Floor of atan(2^-i) in Q2.30.
   function automatic cordic_word_type atan_q30(input int i);
      cordic_word_type r;
      case (i)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021686;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         default: begin
            if (i < 30) r = (34'sd1 <<< (30 - i)) - 34'sd1;
            else r = '0;
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/core/gcd_cordic_rot.sv
// ----------------------------------------------------------------------------
// gcd_cordic_rot
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module gcd_cordic_rot import gcd_pkg::*; #(
   parameter int STAGES = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  cordic_word_type angle,
   output logic            out_valid,
   output cordic_word_type cos_out,
   output cordic_word_type sin_out
);

   cordic_word_type x_d [STAGES+1];
   cordic_word_type y_d [STAGES+1];
   cordic_word_type z_d [STAGES+1];
   logic            v_d [STAGES+1];

   assign x_d[0] = CORDIC_GAIN;
   assign y_d[0] = '0;
   assign z_d[0] = angle;
   assign v_d[0] = in_valid;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      cordic_word_type x_in, y_in, z_in, x_ff, y_ff, z_ff;
      logic v_ff;

      always_comb begin
         if (!z_d[i][WORD_W-1]) begin
            x_in = x_d[i] - (y_d[i] >>> i);
            y_in = y_d[i] + (x_d[i] >>> i);
            z_in = z_d[i] - atan_q30(i);
         end else begin
            x_in = x_d[i] + (y_d[i] >>> i);
            y_in = y_d[i] - (x_d[i] >>> i);
            z_in = z_d[i] + atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_d[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end
      end

      assign x_d[i+1] = x_ff;
      assign y_d[i+1] = y_ff;
      assign z_d[i+1] = z_ff;
      assign v_d[i+1] = v_ff;
   end

   assign out_valid = v_d[STAGES];
   assign cos_out   = x_d[STAGES];
   assign sin_out   = y_d[STAGES];

endmodule

### rtl/core/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined floor square root of (value << 28), one root bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [SQRT_IN_W-1:0]    value,
   output logic                    out_valid,
   output logic [SQRT_STEPS-1:0]   root
);

   // Remainder never exceeds twice the partial root.
   logic [61:0]            v_d   [SQRT_STEPS+1];
   logic [32:0]            rem_d [SQRT_STEPS+1];
   logic [SQRT_STEPS-1:0]  q_d   [SQRT_STEPS+1];
   logic                   val_d [SQRT_STEPS+1];

   assign v_d[0]   = {1'b0, value, 28'd0};
   assign rem_d[0] = '0;
   assign q_d[0]   = '0;
   assign val_d[0] = in_valid;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      logic [34:0] rem2, trial;
      logic [32:0] rem_in, rem_ff;
      logic [SQRT_STEPS-1:0] q_in, q_ff;
      logic [61:0] v_ff;
      logic val_ff;

      always_comb begin
         rem2  = {rem_d[i], v_d[i][61:60]};
         trial = {2'b00, q_d[i], 2'b01};
         if (rem2 >= trial) begin
            rem_in = 33'(rem2 - trial);
            q_in   = {q_d[i][SQRT_STEPS-2:0], 1'b1};
         end else begin
            rem_in = rem2[32:0];
            q_in   = {q_d[i][SQRT_STEPS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff <= 1'b0;
         end else if (adv) begin
            val_ff <= val_d[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            v_ff   <= {v_d[i][59:0], 2'b00};
         end
      end

      assign rem_d[i+1] = rem_ff;
      assign q_d[i+1]   = q_ff;
      assign v_d[i+1]   = v_ff;
      assign val_d[i+1] = val_ff;
   end

   assign out_valid = val_d[SQRT_STEPS];
   assign root      = q_d[SQRT_STEPS];

endmodule

### rtl/core/gcd_cordic_vec.sv
// ----------------------------------------------------------------------------
// gcd_cordic_vec
// Vectoring-mode CORDIC giving atan2(y, x), one step per register stage.
// ----------------------------------------------------------------------------
module gcd_cordic_vec import gcd_pkg::*; #(
   parameter int STAGES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [SQRT_STEPS-1:0] y_val,
   input  logic [SQRT_STEPS-1:0] x_val,
   output logic                  out_valid,
   output cordic_word_type       angle
);

   cordic_word_type x_d [STAGES+1];
   cordic_word_type y_d [STAGES+1];
   cordic_word_type z_d [STAGES+1];
   logic            v_d [STAGES+1];

   assign x_d[0] = cordic_word_type'({3'b000, x_val});
   assign y_d[0] = cordic_word_type'({3'b000, y_val});
   assign z_d[0] = '0;
   assign v_d[0] = in_valid;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      cordic_word_type x_in, y_in, z_in, x_ff, y_ff, z_ff;
      logic v_ff;

      always_comb begin
         if (!y_d[i][WORD_W-1]) begin
            x_in = x_d[i] + (y_d[i] >>> i);
            y_in = y_d[i] - (x_d[i] >>> i);
            z_in = z_d[i] + atan_q30(i);
         end else begin
            x_in = x_d[i] - (y_d[i] >>> i);
            y_in = y_d[i] + (x_d[i] >>> i);
            z_in = z_d[i] - atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_d[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end
      end

      assign x_d[i+1] = x_ff;
      assign y_d[i+1] = y_ff;
      assign z_d[i+1] = z_ff;
      assign v_d[i+1] = v_ff;
   end

   assign out_valid = v_d[STAGES];
   assign angle     = z_d[STAGES];

endmodule

### rtl/core/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great-circle distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_      in          two points, latitude and longitude in 1e-7 degree
//   rsp_      out         distance_mm, great-circle distance in millimeters
//   csr_      in          earth_radius_m, sphere radius in meters
//
// One point pair enters per cycle while the pipeline advances, passing the
// rotation CORDICs, the 31-step square root and the vectoring CORDIC. The
// whole pipeline advances together whenever the output register is empty or
// its beat is taken; otherwise every stage holds. Reset is synchronous and
// clears only the valid bits and the radius register.
// ----------------------------------------------------------------------------
module great_circle_distance_top import gcd_pkg::*; #(
   parameter int CORDIC_STAGES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [34:0]        rsp_distance_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [22:0]        csr_earth_radius_m
);

   // Global advance: the output register is free or is being drained.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // The radius is kept already scaled to millimeters.
   logic [32:0] radius_mm_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_mm_ff <= RADIUS_MM_RESET;
      end else if (csr_valid) begin
         radius_mm_ff <= 33'(csr_earth_radius_m) * 33'(MM_PER_M);
      end
   end

   function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
      if (v > LAT_MAX) return LAT_MAX;
      if (v < -LAT_MAX) return -LAT_MAX;
      return v;
   endfunction

   // Stage 1: clamp latitudes, form differences and wrap the longitude
   // difference back into half a turn.
   logic signed [30:0] lat1_c, lat2_c;
   logic signed [33:0] dlon_raw, dlon_w;
   logic signed [31:0] ang_in [4];
   logic signed [31:0] ang1_ff [4];
   logic v1_ff;

   always_comb begin
      lat1_c   = clamp_lat(req_first_latitude);
      lat2_c   = clamp_lat(req_second_latitude);
      dlon_raw = 34'(req_second_longitude) - 34'(req_first_longitude);
      if (dlon_raw > HALF_TURN) dlon_w = dlon_raw - ONE_TURN;
      else if (dlon_raw < -HALF_TURN) dlon_w = dlon_raw + ONE_TURN;
      else dlon_w = dlon_raw;
      ang_in[0] = 32'(lat2_c) - 32'(lat1_c);
      ang_in[1] = dlon_w[31:0];
      ang_in[2] = 32'(lat1_c);
      ang_in[3] = 32'(lat2_c);
   end

   // Stage 2 multiplies the magnitude by the radian scale; stage 3 rounds,
   // shifts (by 32 for the half angles, 31 for the latitudes) and re-signs.
   cordic_word_type ang3_d [4];
   logic v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff <= ang_in;
      end
   end

   for (genvar ln = 0; ln < 4; ln++) begin : g_lane
      localparam int SH = (ln < 2) ? 32 : 31;
      logic [30:0] mag;
      logic [63:0] rnd;
      logic [30:0] rad;
      logic [62:0] mag2_ff;
      logic        neg2_ff;
      cordic_word_type ang3_ff;

      assign mag = 31'(ang1_ff[ln][31] ? -ang1_ff[ln] : ang1_ff[ln]);
      assign rnd = ({1'b0, mag2_ff} + (64'd1 << (SH - 1))) >> SH;
      assign rad = rnd[30:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            mag2_ff <= 63'(mag) * 63'(RAD_MUL);
            neg2_ff <= ang1_ff[ln][31];
            ang3_ff <= neg2_ff ? -cordic_word_type'(rad) : cordic_word_type'(rad);
         end
      end

      assign ang3_d[ln] = ang3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Sines of the half differences, cosines of the two latitudes.
   cordic_word_type sl, so, c1, c2;
   logic rot_valid;

   gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
      .clock, .reset, .adv, .in_valid(v3_ff), .angle(ang3_d[0]),
      .out_valid(rot_valid), .cos_out(), .sin_out(sl)
   );
   gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
      .clock, .reset, .adv, .in_valid(v3_ff), .angle(ang3_d[1]),
      .out_valid(), .cos_out(), .sin_out(so)
   );
   gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
      .clock, .reset, .adv, .in_valid(v3_ff), .angle(ang3_d[2]),
      .out_valid(), .cos_out(c1), .sin_out()
   );
   gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
      .clock, .reset, .adv, .in_valid(v3_ff), .angle(ang3_d[3]),
      .out_valid(), .cos_out(c2), .sin_out()
   );

   // Haversine term: a = sl^2 + cos1*cos2*so^2, built over three stages.
   logic signed [67:0] sl2_p, c12_p, so2_p, cs_p;
   logic signed [63:0] sl2_ff, c12_ff, so2_ff, cs_ff;
   logic signed [35:0] t1_ff;
   logic signed [33:0] c12_s, so2_s;
   logic signed [39:0] a_sum;
   logic [31:0] a_cl, a6_ff;
   logic [32:0] b6_ff;
   logic v4_ff, v5_ff, v6_ff;

   assign sl2_p = 68'(sl) * 68'(sl);
   assign c12_p = 68'(c1) * 68'(c2);
   assign so2_p = 68'(so) * 68'(so);
   assign c12_s = 34'(c12_ff >>> 30);
   assign so2_s = 34'(so2_ff >>> 30);
   assign cs_p  = 68'(c12_s) * 68'(so2_s);

   always_comb begin
      a_sum = 40'(t1_ff) + 40'(cs_ff >>> 28);
      if (a_sum < 0) a_cl = '0;
      else if (a_sum > 40'sh00FFFFFFFF) a_cl = 32'hFFFFFFFF;
      else a_cl = a_sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sl2_ff <= sl2_p[63:0];
         c12_ff <= c12_p[63:0];
         so2_ff <= so2_p[63:0];
         t1_ff  <= 36'(sl2_ff >>> 28);
         cs_ff  <= cs_p[63:0];
         a6_ff  <= a_cl;
         b6_ff  <= 33'h100000000 - 33'(a_cl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= rot_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // Square roots of a and 1 - a, then their arctangent.
   logic [SQRT_STEPS-1:0] sa, sb;
   logic sqrt_valid, vec_valid;
   cordic_word_type z_ang;

   gcd_isqrt u_sqrt_a (
      .clock, .reset, .adv, .in_valid(v6_ff), .value({1'b0, a6_ff}),
      .out_valid(sqrt_valid), .root(sa)
   );
   gcd_isqrt u_sqrt_b (
      .clock, .reset, .adv, .in_valid(v6_ff), .value(b6_ff),
      .out_valid(), .root(sb)
   );

   gcd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_atan2 (
      .clock, .reset, .adv, .in_valid(sqrt_valid), .y_val(sa), .x_val(sb),
      .out_valid(vec_valid), .angle(z_ang)
   );

   // Scale the half central angle by the radius; round by 2^29 since the
   // full central angle is twice z, then saturate.
   logic [30:0] z_cl;
   logic [63:0] dist_p, dist_ff;
   logic [64:0] dist_r;
   logic [35:0] dist_sh;
   logic [34:0] dist_out_ff;
   logic v7_ff, v8_ff;

   always_comb begin
      if (z_ang < 0) z_cl = '0;
      else if (z_ang > 34'sh07FFFFFFF) z_cl = 31'h7FFFFFFF;
      else z_cl = z_ang[30:0];
      dist_p  = 64'(radius_mm_ff) * 64'(z_cl);
      dist_r  = {1'b0, dist_ff} + 65'h10000000;
      dist_sh = 36'(dist_r >> 29);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff     <= dist_p;
         dist_out_ff <= (dist_sh > 36'(DIST_MAX)) ? DIST_MAX : dist_sh[34:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= vec_valid;
         v8_ff <= v7_ff;
      end
   end

   assign rsp_valid       = v8_ff;
   assign rsp_distance_mm = dist_out_ff;

endmodule
